### hw/rtl/vks_pkg.sv
// ----------------------------------------------------------------------------
// vks_pkg
// Shared types and constants for the velocity key scanner.
// ----------------------------------------------------------------------------
package vks_pkg;

  typedef struct packed {
    logic [6:0]  key_index;
    logic        upper_contact;
    logic        lower_contact;
    logic [31:0] now_time;
  } vks_in_t;

  typedef struct packed {
    logic       event_kind;
    logic [6:0] note_number;
    logic [6:0] velocity;
  } vks_out_t;

  localparam logic EvNoteOn  = 1'b0;
  localparam logic EvNoteOff = 1'b1;

  localparam logic [1:0] PhUp     = 2'd0;
  localparam logic [1:0] PhGoDown = 2'd1;
  localparam logic [1:0] PhDown   = 2'd2;
  localparam logic [1:0] PhGoUp   = 2'd3;

  localparam logic [2:0] RegDebounce = 3'd0;
  localparam logic [2:0] RegPressMin = 3'd1;
  localparam logic [2:0] RegPressMax = 3'd2;
  localparam logic [2:0] RegRelMin   = 3'd3;
  localparam logic [2:0] RegRelMax   = 3'd4;
  localparam logic [2:0] RegBias     = 3'd5;
  localparam logic [2:0] RegNoteBase = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the input transfer
    logic rd_issue;  // present key address to the state memory
    logic eval;      // run the contact logic on the read state
    logic div_start; // start the shared divider
    logic mul_step;  // select of the multiply-stage sequence
    logic [2:0] step;
  } vks_cmd_t;

  typedef struct packed {
    logic key_ok;
    logic has_event;
    logic is_on;
    logic div_busy;
    logic special;   // velocity already decided without division
  } vks_sts_t;

endpackage

### hw/rtl/vks_divider.sv
// ----------------------------------------------------------------------------
// vks_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vks_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [37:0] num_i,
  input  logic [20:0] den_i,
  output logic        busy_o,
  output logic [37:0] quo_o
);
  import vks_pkg::*;

  logic [37:0] quo_q, quo_d;
  logic [21:0] rem_q, rem_d;
  logic [20:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [21:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[20:0], quo_q[37]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = 6'd38;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[36:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[36:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

### hw/rtl/vks_datapath.sv
// ----------------------------------------------------------------------------
// vks_datapath
// Key state memory, contact logic and velocity arithmetic.
// ----------------------------------------------------------------------------
module vks_datapath #(
  parameter int unsigned NumKeys = 88
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vks_pkg::vks_cmd_t cmd_i,
  output vks_pkg::vks_sts_t sts_o,
  input  vks_pkg::vks_in_t  in_data_i,
  output vks_pkg::vks_out_t out_data_o,
  input  logic [15:0]       debounce_i,
  input  logic [19:0]       pmin_i,
  input  logic [19:0]       pmax_i,
  input  logic [19:0]       rmin_i,
  input  logic [19:0]       rmax_i,
  input  logic [15:0]       bias_i,
  input  logic [5:0]        note_base_i
);
  import vks_pkg::*;

  localparam int unsigned KW = (NumKeys > 1) ? $clog2(NumKeys) : 1;

  // Per-key state: phase and latches in flip-flops (reset), stamps in memory.
  logic [1:0]  phase_q [NumKeys];
  logic        ulat_q  [NumKeys];
  logic        llat_q  [NumKeys];
  logic [95:0] stamp_mem [NumKeys];
  logic [NumKeys-1:0] stamp_vld_q;

  vks_in_t     in_q;
  logic [KW-1:0] key;
  logic        key_ok;
  logic [95:0] rd_q;
  logic        rd_vld_q;
  logic [1:0]  ph_rd_q;
  logic        ul_rd_q, ll_rd_q;

  assign key    = in_q.key_index[KW-1:0];
  assign key_ok = ({25'd0, in_q.key_index} < 32'(NumKeys));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
    if (cmd_i.rd_issue) begin
      rd_q    <= stamp_mem[key];
      ph_rd_q <= phase_q[key];
      ul_rd_q <= ulat_q[key];
      ll_rd_q <= llat_q[key];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else if (cmd_i.rd_issue) rd_vld_q <= key_ok && stamp_vld_q[key];
  end

  // Contact logic
  logic [31:0] ust, lst, pst, cut, now;
  logic [1:0]  ph0, ph1, ph2;
  logic        ul, ll, ev, ev_on;
  logic [31:0] ust_n, lst_n, pst_n;

  always_comb begin
    now = in_q.now_time;
    ust = rd_vld_q ? rd_q[95:64] : 32'd0;
    lst = rd_vld_q ? rd_q[63:32] : 32'd0;
    pst = rd_vld_q ? rd_q[31:0]  : 32'd0;
    cut = now - {16'd0, debounce_i};
    ph0 = ph_rd_q;
    ul  = ul_rd_q;
    ll  = ll_rd_q;
    ust_n = ust; lst_n = lst; pst_n = pst;
    ph1 = ph0; ph2 = ph0;
    ev = 1'b0; ev_on = 1'b0;
    if (ust < cut) begin
      if (in_q.upper_contact && !ul && ph0 == PhUp) begin
        ul = 1'b1; ust_n = now; ph1 = PhGoDown; pst_n = now;
      end else if (!in_q.upper_contact && ul && ph0 == PhGoUp) begin
        ul = 1'b0; ust_n = now; ph1 = PhUp; ev = 1'b1; ev_on = 1'b0;
      end
    end
    ph2 = ph1;
    if (lst < cut) begin
      if (in_q.lower_contact && !ll && ph1 == PhGoDown) begin
        ll = 1'b1; lst_n = now; ph2 = PhDown; ev = 1'b1; ev_on = 1'b1;
      end else if (!in_q.lower_contact && ll && ph1 == PhDown) begin
        ll = 1'b0; lst_n = now; ph2 = PhGoUp; pst_n = now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeys; i++) begin
        phase_q[i] <= PhUp;
        ulat_q[i]  <= 1'b0;
        llat_q[i]  <= 1'b0;
      end
      stamp_vld_q <= '0;
    end else if (cmd_i.eval && key_ok) begin
      phase_q[key]     <= ph2;
      ulat_q[key]      <= ul;
      llat_q[key]      <= ll;
      stamp_vld_q[key] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && key_ok) stamp_mem[key] <= {ust_n, lst_n, pst_n};
  end

  // Velocity arithmetic
  logic        is_on_q, has_ev_q, special_q;
  logic [31:0] elapsed_q;
  logic [19:0] lo, hi;
  logic [20:0] range_q;
  logic [20:0] rt_q;       // range - t
  logic [6:0]  vel_q;
  logic [6:0]  note_q;
  logic [31:0] e_cl;
  logic [16:0] xq_q;
  logic [16:0] xb_q;
  logic [17:0] den_q;

  logic        div_start;
  logic [37:0] div_num, div_quo;
  logic [20:0] div_den;
  logic        div_busy;

  assign lo = is_on_q ? pmin_i : rmin_i;
  assign hi = is_on_q ? pmax_i : rmax_i;

  always_comb begin
    e_cl = elapsed_q;
    if (e_cl < {12'd0, lo}) e_cl = {12'd0, lo};
    else if (e_cl > {12'd0, hi}) e_cl = {12'd0, hi};
  end

  logic [32:0] prod;
  always_comb begin
    prod = '0;
    case (cmd_i.step)
      3'd3: prod = 33'(xq_q) * 33'(bias_i);
      3'd6: prod = 33'(div_quo[16:0]) * 33'd126;
      default: prod = '0;
    endcase
  end

  // Steps: 1 setup, 2 xq/off-velocity division, 3 xb, 4 den, 5 vq division, 6 final
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      is_on_q   <= ev_on;
      elapsed_q <= now - pst_n;
      note_q    <= in_q.key_index + {1'b0, note_base_i};
    end
    if (cmd_i.mul_step) begin
      case (cmd_i.step)
        3'd1: begin
          range_q   <= {1'b0, hi} - {1'b0, lo};
          rt_q      <= {1'b0, hi} - 21'(e_cl);
          special_q <= (hi <= lo);
          vel_q     <= 7'd127;
        end
        3'd2: begin
          if (!is_on_q) vel_q <= div_quo[6:0] + 7'd1;
        end
        3'd3: begin
          xq_q <= div_quo[16:0];
          xb_q <= 17'((33'(div_quo[16:0]) * 33'(bias_i)) >> 16);
        end
        3'd4: begin
          den_q <= 18'(xb_q) + 18'd65536 - 18'(xq_q);
          if ((18'(xb_q) + 18'd65536 - 18'(xq_q)) == 18'd0) begin
            special_q <= 1'b1;
            vel_q     <= 7'd1;
          end
        end
        3'd6: begin
          vel_q <= 7'((div_quo[16:0] > 17'd65536 ? 33'd8257536 : prod) >> 16) + 7'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    div_start = cmd_i.div_start;
    div_num = '0;
    div_den = range_q;
    if (cmd_i.step == 3'd2) begin
      div_num = is_on_q ? {1'b0, rt_q, 16'd0} : 38'(rt_q) * 38'd126;
      div_den = range_q;
    end else begin
      div_num = {5'd0, xb_q, 16'd0};
      div_den = {3'd0, den_q};
    end
  end

  vks_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) has_ev_q <= 1'b0;
    else if (cmd_i.eval) has_ev_q <= ev && key_ok;
  end

  assign sts_o.key_ok    = key_ok;
  assign sts_o.has_event = has_ev_q;
  assign sts_o.is_on     = is_on_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.special   = special_q;

  assign out_data_o.event_kind  = is_on_q ? EvNoteOn : EvNoteOff;
  assign out_data_o.note_number = note_q;
  assign out_data_o.velocity    = vel_q;
endmodule

### hw/rtl/vks_ctrl.sv
// ----------------------------------------------------------------------------
// vks_ctrl
// Sequencer: input transfer, state read/update, velocity steps, output.
// ----------------------------------------------------------------------------
module vks_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vks_pkg::vks_cmd_t cmd_o,
  input  vks_pkg::vks_sts_t sts_i
);
  import vks_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StRead, StEval, StSetup, StDiv1Go, StDiv1, StXb, StDen,
    StDiv2Go, StDiv2, StFinal, StOut
  } state_e;

  state_e state_q;
  logic   outv_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load     = (state_q == StIdle) && in_valid_i;
    cmd_o.rd_issue = (state_q == StRead);
    cmd_o.eval     = (state_q == StEval);
    case (state_q)
      StSetup:  begin cmd_o.mul_step = 1'b1; cmd_o.step = 3'd1; end
      StDiv1Go: begin cmd_o.div_start = 1'b1; cmd_o.step = 3'd2; end
      StDiv1:   begin cmd_o.step = 3'd2; cmd_o.mul_step = !sts_i.div_busy; end
      StXb:     begin cmd_o.mul_step = 1'b1; cmd_o.step = 3'd3; end
      StDen:    begin cmd_o.mul_step = 1'b1; cmd_o.step = 3'd4; end
      StDiv2Go: begin cmd_o.div_start = 1'b1; cmd_o.step = 3'd5; end
      StDiv2:   cmd_o.step = 3'd5;
      StFinal:  begin cmd_o.mul_step = 1'b1; cmd_o.step = 3'd6; end
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      outv_q  <= 1'b0;
    end else begin
      case (state_q)
        StIdle:   if (in_valid_i) state_q <= StRead;
        StRead:   state_q <= StEval;
        StEval:   state_q <= StSetup;
        StSetup:  state_q <= sts_i.has_event ? StDiv1Go : StIdle;
        StDiv1Go: state_q <= sts_i.special ? StOut : StDiv1;
        StDiv1: begin
          if (!sts_i.div_busy) state_q <= sts_i.is_on ? StXb : StOut;
        end
        StXb:     state_q <= StDen;
        StDen:    state_q <= StDiv2Go;
        StDiv2Go: state_q <= sts_i.special ? StOut : StDiv2;
        StDiv2:   if (!sts_i.div_busy) state_q <= StFinal;
        StFinal:  state_q <= StOut;
        StOut: begin
          if (!outv_q) outv_q <= 1'b1;
          else if (!out_stall_i) begin
            outv_q  <= 1'b0;
            state_q <= StIdle;
          end
        end
        default:  state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = outv_q;
endmodule

### hw/rtl/velocity_key_scanner.sv
// ----------------------------------------------------------------------------
// velocity_key_scanner
// Two-contact velocity keyboard scanner with APB configuration.
// ----------------------------------------------------------------------------
// One sample is processed at a time. A sample with no event frees the input
// after the read, evaluate and setup states. Divisions run on the shared
// one-bit-per-cycle 38-bit divider: a note-off result uses at most one
// division and a note-on result at most two. The next sample is taken only
// after the result transfers.
module velocity_key_scanner #(
  parameter int unsigned NUM_KEYS = 88
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vks_pkg::vks_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vks_pkg::vks_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import vks_pkg::*;

  logic [15:0] deb_q, bias_q;
  logic [19:0] pmin_q, pmax_q, rmin_q, rmax_q;
  logic [5:0]  nb_q;
  logic [2:0]  ridx;

  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= 16'd3000;
      pmin_q <= 20'd4000;
      pmax_q <= 20'd120000;
      rmin_q <= 20'd4000;
      rmax_q <= 20'd80000;
      bias_q <= 16'd2810;
      nb_q   <= 6'd21;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        RegDebounce: deb_q  <= pwdata[15:0];
        RegPressMin: pmin_q <= pwdata[19:0];
        RegPressMax: pmax_q <= pwdata[19:0];
        RegRelMin:   rmin_q <= pwdata[19:0];
        RegRelMax:   rmax_q <= pwdata[19:0];
        RegBias:     bias_q <= pwdata[15:0];
        RegNoteBase: nb_q   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegDebounce: prdata = {16'd0, deb_q};
      RegPressMin: prdata = {12'd0, pmin_q};
      RegPressMax: prdata = {12'd0, pmax_q};
      RegRelMin:   prdata = {12'd0, rmin_q};
      RegRelMax:   prdata = {12'd0, rmax_q};
      RegBias:     prdata = {16'd0, bias_q};
      RegNoteBase: prdata = {26'd0, nb_q};
      default:     prdata = '0;
    endcase
  end

  vks_cmd_t cmd;
  vks_sts_t sts;

  vks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  vks_datapath #(.NumKeys(NUM_KEYS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .debounce_i  (deb_q),
    .pmin_i      (pmin_q),
    .pmax_i      (pmax_q),
    .rmin_i      (rmin_q),
    .rmax_i      (rmax_q),
    .bias_i      (bias_q),
    .note_base_i (nb_q)
  );
endmodule

### hw/rtl/vks_checker.sv
// ----------------------------------------------------------------------------
// vks_checker
// Port-level checks for the velocity key scanner.
// ----------------------------------------------------------------------------
module vks_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input vks_pkg::vks_out_t out_data_o,
  input logic              pready
);
  import vks_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.velocity != 7'd0)
    else $error("velocity zero");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer accepted back to back");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule

bind velocity_key_scanner vks_checker u_vks_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

### tb/sv/velocity_key_scanner_chk.sv
// ----------------------------------------------------------------------------
// velocity_key_scanner_chk
// Watches the sample, event and register channels of the key scanner, keeps
// its own per-key contact state and register copies, predicts each note event
// and compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
module velocity_key_scanner_chk #(
  parameter int unsigned NUM_KEYS = 88
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  vks_pkg::vks_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  vks_pkg::vks_out_t out_data_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                pending_o,
  output int                errors_o
);
  import vks_pkg::*;

  logic [15:0] dbnc_us;
  logic [19:0] on_lo, on_hi, off_lo, off_hi;
  logic [15:0] bias_q16;
  logic [5:0]  base_note;

  logic [1:0]  phase_q   [NUM_KEYS];
  logic        up_lat_q  [NUM_KEYS];
  logic        lo_lat_q  [NUM_KEYS];
  logic [31:0] up_stamp_q[NUM_KEYS];
  logic [31:0] lo_stamp_q[NUM_KEYS];
  logic [31:0] press_t_q [NUM_KEYS];

  vks_out_t events_due[$];
  int       errors;

  assign pending_o = events_due.size();
  assign errors_o  = errors;

  function automatic logic [63:0] win_offset(logic [31:0] el, logic [19:0] lo,
                                             logic [19:0] hi);
    logic [31:0] e;
    e = el;
    if (e < lo) e = lo;
    else if (e > hi) e = hi;
    return 64'(e - lo);
  endfunction

  function automatic logic [6:0] strike_vel(logic [31:0] el);
    logic [63:0] rng, t, xq, xb, den, vq;
    if (on_hi <= on_lo) return 7'd127;
    rng = 64'(on_hi - on_lo);
    t   = win_offset(el, on_lo, on_hi);
    xq  = ((rng - t) << 16) / rng;
    xb  = (xq * 64'(bias_q16)) >> 16;
    den = xb + 64'd65536 - xq;
    if (den == 0) return 7'd1;
    vq = (xb << 16) / den;
    if (vq > 64'd65536) vq = 64'd65536;
    return 7'(((64'd126 * vq) >> 16) + 1);
  endfunction

  function automatic logic [6:0] lift_vel(logic [31:0] el);
    logic [63:0] rng, t;
    if (off_hi <= off_lo) return 7'd127;
    rng = 64'(off_hi - off_lo);
    t   = win_offset(el, off_lo, off_hi);
    return 7'((64'd126 * (rng - t)) / rng + 1);
  endfunction

  task automatic scan_sample(vks_in_t s);
    logic [31:0] cut;
    int          k;
    vks_out_t    ev;
    bit          hit;
    cut = s.now_time - 32'(dbnc_us);
    k   = s.key_index;
    hit = 0;
    if (k >= NUM_KEYS) return;
    ev.note_number = 7'(k) + 7'(base_note);
    if (up_stamp_q[k] < cut) begin
      if (s.upper_contact && !up_lat_q[k] && phase_q[k] == PhUp) begin
        up_lat_q[k]   = 1'b1;
        up_stamp_q[k] = s.now_time;
        phase_q[k]    = PhGoDown;
        press_t_q[k]  = s.now_time;
      end else if (!s.upper_contact && up_lat_q[k] && phase_q[k] == PhGoUp) begin
        up_lat_q[k]   = 1'b0;
        up_stamp_q[k] = s.now_time;
        phase_q[k]    = PhUp;
        ev.event_kind = EvNoteOff;
        ev.velocity   = lift_vel(s.now_time - press_t_q[k]);
        hit = 1;
      end
    end
    if (lo_stamp_q[k] < cut) begin
      if (s.lower_contact && !lo_lat_q[k] && phase_q[k] == PhGoDown) begin
        lo_lat_q[k]   = 1'b1;
        lo_stamp_q[k] = s.now_time;
        phase_q[k]    = PhDown;
        ev.event_kind = EvNoteOn;
        ev.velocity   = strike_vel(s.now_time - press_t_q[k]);
        hit = 1;
      end else if (!s.lower_contact && lo_lat_q[k] && phase_q[k] == PhDown) begin
        lo_lat_q[k]   = 1'b0;
        lo_stamp_q[k] = s.now_time;
        phase_q[k]    = PhGoUp;
        press_t_q[k]  = s.now_time;
      end
    end
    if (hit) events_due.push_back(ev);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vks_out_t want;
    if (!rst_ni) begin
      dbnc_us   = 16'd3000;
      on_lo     = 20'd4000;
      on_hi     = 20'd120000;
      off_lo    = 20'd4000;
      off_hi    = 20'd80000;
      bias_q16  = 16'd2810;
      base_note = 6'd21;
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_q[k]    = PhUp;
        up_lat_q[k]   = 1'b0;
        lo_lat_q[k]   = 1'b0;
        up_stamp_q[k] = '0;
        lo_stamp_q[k] = '0;
        press_t_q[k]  = '0;
      end
      events_due.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegDebounce: dbnc_us   = pwdata[15:0];
          RegPressMin: on_lo     = pwdata[19:0];
          RegPressMax: on_hi     = pwdata[19:0];
          RegRelMin:   off_lo    = pwdata[19:0];
          RegRelMax:   off_hi    = pwdata[19:0];
          RegBias:     bias_q16  = pwdata[15:0];
          RegNoteBase: base_note = pwdata[5:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event: actual %p", $time, out_data_i);
          errors++;
        end else begin
          want = events_due.pop_front();
          if (want.event_kind !== out_data_i.event_kind) begin
            $display("%0t: event_kind expected %0d actual %0d", $time,
                     want.event_kind, out_data_i.event_kind);
            errors++;
          end
          if (want.note_number !== out_data_i.note_number) begin
            $display("%0t: note_number expected %0d actual %0d", $time,
                     want.note_number, out_data_i.note_number);
            errors++;
          end
          if (want.velocity !== out_data_i.velocity) begin
            $display("%0t: velocity expected %0d actual %0d", $time,
                     want.velocity, out_data_i.velocity);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) scan_sample(in_data_i);
    end
  end

endmodule

### tb/sv/velocity_key_scanner_tb.sv
// ----------------------------------------------------------------------------
// velocity_key_scanner_tb
// Drives key samples and register writes into the scanner over several
// register settings: directed press/release strokes first, then random
// strokes mixed with bounce and noise, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module velocity_key_scanner_tb;
  import vks_pkg::*;

  localparam int NumKeys = 88;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  vks_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  vks_out_t out_data_o;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          pending, errors;

  bit          hold_off;
  int          burst_left;
  logic [31:0] sim_us;
  logic [1:0]  stroke_step[NumKeys];

  velocity_key_scanner #(.NUM_KEYS(NumKeys)) dut (.*);

  velocity_key_scanner_chk #(.NUM_KEYS(NumKeys)) u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("velocity_key_scanner: mismatch");
    $finish;
  end

  // sink: mostly random stall patterns, plus a long hold-off on each request
  initial begin
    int mode;
    out_stall_i = 1'b0;
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      mode = $urandom_range(2);
      repeat ($urandom_range(8, 64)) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(1) == 0);
          default: out_stall_i <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  task automatic send(logic [6:0] key, logic up, logic lo, logic [31:0] t);
    in_valid_i <= 1'b1;
    in_data_i  <= '{key_index: key, upper_contact: up, lower_contact: lo, now_time: t};
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // full stroke: upper closes, lower closes dp later, lower opens, upper opens dr later
  task automatic stroke(logic [6:0] key, logic [31:0] t, logic [31:0] dp, logic [31:0] dr);
    send(key, 1'b1, 1'b0, t);
    send(key, 1'b1, 1'b1, t + dp);
    send(key, 1'b1, 1'b0, t + dp + 32'd200000);
    send(key, 1'b0, 1'b0, t + dp + 32'd200000 + dr);
  endtask

  task automatic directed(logic [31:0] t);
    // both contacts close in one sample: zero interval
    send(7'd0, 1'b1, 1'b1, t);
    send(7'd0, 1'b0, 1'b0, t + 32'd100000);
    send(7'd0, 1'b0, 1'b0, t + 32'd100000);
    send(7'd0, 1'b0, 1'b0, t + 32'd200000);
    stroke(7'd87, t + 32'd300000, 32'd2000000, 32'd2000000);
    stroke(7'd40, t + 32'd5000000, 32'd60000, 32'd30000);
    // out-of-range keys are ignored
    send(7'd88, 1'b1, 1'b1, t + 32'd9000000);
    send(7'd127, 1'b1, 1'b1, t + 32'd9000000);
    // bounce right after a close, inside the debounce time at the reset settings
    send(7'd5, 1'b1, 1'b0, t + 32'd9100000);
    send(7'd5, 1'b0, 1'b0, t + 32'd9100010);
    send(7'd5, 1'b1, 1'b1, t + 32'd9200000);
  endtask

  task automatic random_items(int n);
    int r, k;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 75) begin
        k = $urandom_range(NumKeys - 1);
        sim_us += ($urandom_range(3) == 0) ? $urandom_range(0, 5000)
                                          : $urandom_range(0, 160000);
        case (stroke_step[k])
          2'd0: send(7'(k), 1'b1, 1'b0, sim_us);
          2'd1: send(7'(k), 1'b1, 1'b1, sim_us);
          2'd2: send(7'(k), 1'b1, 1'b0, sim_us);
          default: send(7'(k), 1'b0, 1'b0, sim_us);
        endcase
        stroke_step[k]++;
      end else if (r < 88) begin
        sim_us += $urandom_range(0, 2000);
        send(7'($urandom_range(NumKeys - 1)), 1'($urandom), 1'($urandom), sim_us);
      end else begin
        send(7'($urandom_range(127)), 1'($urandom), 1'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    hold_off    = 0;
    burst_left  = 0;
    sim_us      = 32'hFF00_0000 + $urandom_range(0, 1000000);
    for (int k = 0; k < NumKeys; k++) stroke_step[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    directed(32'd1000000);
    hold_off = 1;
    random_items(160);
    drain();

    // widest windows, longest debounce, steepest bias, note base 39
    reg_write(RegDebounce, 32'd65535);
    reg_write(RegPressMin, 32'd0);
    reg_write(RegPressMax, 32'hFFFFF);
    reg_write(RegRelMin, 32'd0);
    reg_write(RegRelMax, 32'hFFFFF);
    reg_write(RegBias, 32'hFFFF);
    reg_write(RegNoteBase, 32'd39);
    random_items(160);
    drain();

    // no debounce, zero bias, empty release window
    reg_write(RegDebounce, 32'd0);
    reg_write(RegPressMin, 32'd0);
    reg_write(RegPressMax, 32'd50000);
    reg_write(RegRelMin, 32'd30000);
    reg_write(RegRelMax, 32'd30000);
    reg_write(RegBias, 32'd0);
    reg_write(RegNoteBase, 32'd0);
    directed(32'd700000000);
    random_items(140);
    drain();

    // empty press window (max below min)
    reg_write(RegPressMin, 32'hFFFFF);
    reg_write(RegPressMax, 32'd1000);
    reg_write(RegRelMin, 32'd1000);
    reg_write(RegRelMax, 32'd200000);
    reg_write(RegDebounce, 32'd100);
    random_items(130);
    drain();

    repeat (2) begin
      reg_write(RegDebounce, $urandom_range(0, 8000));
      reg_write(RegPressMin, $urandom_range(0, 20000));
      reg_write(RegPressMax, $urandom_range(10000, 200000));
      reg_write(RegRelMin, $urandom_range(0, 20000));
      reg_write(RegRelMax, $urandom_range(10000, 200000));
      reg_write(RegBias, $urandom_range(0, 65535));
      reg_write(RegNoteBase, $urandom_range(0, 39));
      hold_off = 1;
      random_items(110);
      drain();
    end

    if (errors == 0) begin
      $display("velocity_key_scanner: match");
    end else begin
      $display("velocity_key_scanner: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/vks_pkg.sv
hw/rtl/vks_divider.sv
hw/rtl/vks_datapath.sv
hw/rtl/vks_ctrl.sv
hw/rtl/velocity_key_scanner.sv
hw/rtl/vks_checker.sv
tb/sv/velocity_key_scanner_chk.sv
tb/sv/velocity_key_scanner_tb.sv
